/* rtl/tlr_pkg.sv */
// thick line rasterizer package: widths, codes, state enums and queue/result structs
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps

package tlr_pkg;

	// coordinate width of the endpoint fields
	localparam int COORD_BITS = 12;
	// default longest width run
	localparam int RUN_LIMIT_DEF = 31;

	// derived widths
	localparam int DW    = COORD_BITS + 1;      // absolute deltas
	localparam int ERRW  = COORD_BITS + 3;      // line error term, signed
	localparam int EW    = COORD_BITS + 7;      // run error term, signed
	localparam int RW    = COORD_BITS + 6;      // run coordinate, signed
	localparam int DSQW  = 2 * DW + 1;          // dx^2 + dy^2
	localparam int W1SQW = 11;                  // (line_width+1)^2
	localparam int THRW  = DSQW + W1SQW;        // D*(w+1)^2
	localparam int SQW   = 2 * (EW - 1);        // e2^2
	localparam int LHSW  = SQW + 2;             // 4*e2^2

	// fixed field widths
	localparam int MAPW   = 12;
	localparam int LWW    = 5;
	localparam int IDXW   = 22;
	localparam int CFGIW  = 2;
	localparam int QDEPTH = 2;

	// configuration register indexes
	typedef enum logic [CFGIW-1:0] {
		CFG_MAP_WIDTH  = 2'd0,
		CFG_MAP_HEIGHT = 2'd1,
		CFG_LINE_WIDTH = 2'd2
	} cfg_idx_t;

	// input kinds
	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQ,
		F_SUM
	} front_st_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AXIS,
		B_SQ,
		B_TEST,
		B_EMIT,
		B_END
	} back_st_t;

	// one step job handed from front to back
	typedef struct packed {
		logic                          idle;
		logic                          done;
		logic signed [COORD_BITS-1:0]  cx;
		logic signed [COORD_BITS-1:0]  cy;
		logic signed [COORD_BITS-1:0]  dest_x;
		logic signed [COORD_BITS-1:0]  dest_y;
		logic                          sx_neg;
		logic                          sy_neg;
		logic                          do_ry;
		logic                          do_rx;
		logic signed [EW-1:0]          ry_e2;
		logic signed [EW-1:0]          rx_e2;
		logic [DW-1:0]                 abs_dx;
		logic [DW-1:0]                 abs_dy;
		logic [THRW-1:0]               thr;
	} job_t;

	// one result item
	typedef struct packed {
		logic            pixel_valid;
		logic            in_map;
		logic [IDXW-1:0] tile_index;
		logic            run_cut;
		logic            last_of_step;
		logic            line_done;
	} result_t;

endpackage

/* rtl/tlr_if.sv */
// valid/ready channel interfaces of the thick line rasterizer
// depends on tlr_pkg
`timescale 1ns / 1ps

interface tlr_item_if import tlr_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [COORD_BITS-1:0]  start_x;
	logic signed [COORD_BITS-1:0]  start_y;
	logic signed [COORD_BITS-1:0]  end_x;
	logic signed [COORD_BITS-1:0]  end_y;
	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlr_res_if import tlr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            pixel_valid;
	logic            in_map;
	logic [IDXW-1:0] tile_index;
	logic            run_cut;
	logic            last_of_step;
	logic            line_done;
	modport source (output valid, pixel_valid, in_map, tile_index, run_cut, last_of_step,
		line_done, input ready);
	modport sink (input valid, pixel_valid, in_map, tile_index, run_cut, last_of_step,
		line_done, output ready);
endinterface

interface tlr_cfg_if import tlr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFGIW-1:0] index;
	logic [MAPW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tlr_fifo.sv */
// two-entry job queue between front and back
// depends on tlr_pkg
`timescale 1ns / 1ps

module tlr_fifo import tlr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(QDEPTH);

	job_t              mem_q [QDEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/tlr_front.sv */
// front of the rasterizer: takes start and step items, keeps the line walk state
// and queues one job per step; depends on tlr_pkg and tlr_if
`timescale 1ns / 1ps

module tlr_front import tlr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	tlr_item_if.sink         item,
	input  logic [LWW-1:0]   line_width,
	input  logic             q_full,
	output logic             q_push,
	output job_t             q_job
);

	front_st_t st_q, st_n;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, dest_x_q, dest_y_q;
	logic [DW-1:0]                abs_dx_q, abs_dy_q;
	logic [1:0]                   step_signs_q;
	logic signed [ERRW-1:0]       err_q;
	logic                         active_q;
	logic [2*DW-1:0]              dxsq_q, dysq_q;
	logic [DSQW-1:0]              dsum_q;
	logic [W1SQW-1:0]             w1sq_q;

	logic                         acc, acc_start, acc_step;
	logic signed [DW-1:0]         x0, y0, x1, y1;
	logic [DW-1:0]                adx_n, ady_n;
	logic signed [ERRW:0]         e2x, adx_s, ady_s;
	logic                         cond1, done1, cond2, done2;
	logic signed [ERRW-1:0]       err1, err2;
	logic [LWW:0]                 w1;
	logic [DSQW:0]                dsum_n;

	assign acc       = item.valid && item.ready;
	assign acc_start = acc && (item.kind == KIND_START);
	assign acc_step  = acc && (item.kind == KIND_STEP);

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			F_IDLE: if (acc_start) st_n = F_SQ;
			F_SQ:   st_n = F_SUM;
			F_SUM:  st_n = F_IDLE;
			default: st_n = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready = (st_q == F_IDLE) && !q_full;
		q_push     = acc_step;
	end

	// start setup: deltas and directions
	assign x0 = DW'(item.start_x);
	assign y0 = DW'(item.start_y);
	assign x1 = DW'(item.end_x);
	assign y1 = DW'(item.end_y);
	assign adx_n = (x1 > x0) ? DW'(x1 - x0) : DW'(x0 - x1);
	assign ady_n = (y1 > y0) ? DW'(y1 - y0) : DW'(y0 - y1);

	// step decisions on the current error term
	assign e2x   = {err_q, 1'b0};
	assign adx_s = (ERRW+1)'({1'b0, abs_dx_q});
	assign ady_s = (ERRW+1)'({1'b0, abs_dy_q});
	assign cond1 = e2x >= -adx_s;
	assign done1 = cond1 && (cur_x_q == dest_x_q);
	assign cond2 = !done1 && (e2x <= ady_s);
	assign done2 = cond2 && (cur_y_q == dest_y_q);
	assign err1  = (cond1 && !done1) ? ERRW'(err_q - ERRW'(abs_dy_q)) : err_q;
	assign err2  = (cond2 && !done2) ? ERRW'(err1 + ERRW'(abs_dx_q)) : err1;

	// squared length for the width test
	assign dsum_n = (DSQW+1)'(dxsq_q) + (DSQW+1)'(dysq_q);
	assign w1     = (LWW+1)'(line_width) + 1'b1;

	// job for the back end
	always_comb begin
		q_job        = '0;
		q_job.idle   = !active_q;
		q_job.done   = !active_q || done1 || done2;
		q_job.cx     = cur_x_q;
		q_job.cy     = cur_y_q;
		q_job.dest_x = dest_x_q;
		q_job.dest_y = dest_y_q;
		q_job.sx_neg = step_signs_q[0];
		q_job.sy_neg = step_signs_q[1];
		q_job.do_ry  = active_q && cond1;
		q_job.do_rx  = active_q && cond2;
		q_job.ry_e2  = EW'(err_q) + EW'(abs_dy_q);
		q_job.rx_e2  = EW'(abs_dx_q) - EW'(err_q);
		q_job.abs_dx = abs_dx_q;
		q_job.abs_dy = abs_dy_q;
		q_job.thr    = THRW'(dsum_q * w1sq_q);
	end

	// fsm and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= F_IDLE;
			active_q     <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			dest_x_q     <= '0;
			dest_y_q     <= '0;
			abs_dx_q     <= '0;
			abs_dy_q     <= '0;
			step_signs_q <= '0;
			err_q        <= '0;
		end else begin
			st_q <= st_n;
			if (acc_start) begin
				cur_x_q      <= item.start_x;
				cur_y_q      <= item.start_y;
				dest_x_q     <= item.end_x;
				dest_y_q     <= item.end_y;
				abs_dx_q     <= adx_n;
				abs_dy_q     <= ady_n;
				step_signs_q <= {!(y0 < y1), !(x0 < x1)};
				err_q        <= ERRW'(adx_n) - ERRW'(ady_n);
				active_q     <= 1'b1;
			end else if (acc_step && active_q) begin
				err_q <= err2;
				if (cond1 && !done1) begin
					cur_x_q <= step_signs_q[0] ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				end
				if (cond2 && !done2) begin
					cur_y_q <= step_signs_q[1] ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				end
				if (done1 || done2) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// squares of the deltas, then their sum (one when both are zero)
	always_ff @(posedge clk) begin
		w1sq_q <= W1SQW'(w1 * w1);
		if (st_q == F_SQ) begin
			dxsq_q <= abs_dx_q * abs_dx_q;
			dysq_q <= abs_dy_q * abs_dy_q;
		end
		if (st_q == F_SUM) begin
			dsum_q <= (dsum_n == '0) ? DSQW'(1) : DSQW'(dsum_n);
		end
	end

endmodule

/* rtl/tlr_back.sv */
// back of the rasterizer: walks the axis pixel and up to two width runs of each job,
// holds the newest pixel until its flags are known; depends on tlr_pkg and tlr_if
`timescale 1ns / 1ps

module tlr_back import tlr_pkg::*; #(
	parameter int RUN_LIMIT = RUN_LIMIT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [MAPW-1:0] map_width,
	input  logic [MAPW-1:0] map_height,
	input  logic            q_empty,
	input  job_t            q_job,
	output logic            q_pop,
	tlr_res_if.source       res
);

	localparam int KW = $clog2(RUN_LIMIT + 1);

	back_st_t st_q, st_n;
	job_t     job_q;
	logic     ay_q;                  // current run moves along y
	logic signed [RW-1:0] mv_q;
	logic signed [EW-1:0] e2_q;
	logic [KW-1:0]        k_q;
	logic [SQW-1:0]       sq_q;
	result_t pend_q, out_q;
	logic    pend_v_q, out_v_q;

	logic can_emit, do_emit, do_flush, ld_run, ld_ay, adv, set_cut;
	logic run_ok, stop;
	logic signed [RW-1:0] px, py, tgt, fix;
	logic signed [RW-1:0] dir;
	logic [EW-1:0]        inc;
	logic                 major, in_bounds;
	logic [LHSW-1:0]      lhs;
	result_t              pix;
	result_t              last_pix;
	logic                 next_rx;

	function automatic logic q_job_run(input job_t j);
		return j.do_ry || j.do_rx;
	endfunction

	// the held pixel may move on when the output register frees
	assign can_emit = !pend_v_q || !out_v_q || res.ready;

	// run parameters
	assign fix   = ay_q ? RW'(job_q.cx) : RW'(job_q.cy);
	assign tgt   = ay_q ? RW'(job_q.dest_y) : RW'(job_q.dest_x);
	assign dir   = (ay_q ? job_q.sy_neg : job_q.sx_neg) ? -RW'(1) : RW'(1);
	assign inc   = ay_q ? EW'(job_q.abs_dx) : EW'(job_q.abs_dy);
	assign major = ay_q ? (job_q.abs_dx > job_q.abs_dy) : (job_q.abs_dx < job_q.abs_dy);

	// width test on the registered square
	assign lhs    = {sq_q, 2'b00};
	assign run_ok = (e2_q[EW-1] || (lhs < LHSW'(job_q.thr))) && ((tgt != mv_q) || major);
	assign stop   = !run_ok || (k_q == KW'(RUN_LIMIT));
	assign next_rx = ay_q && job_q.do_rx;

	// pixel coordinate, clipping and tile index
	always_comb begin
		if (st_q == B_AXIS) begin
			px = RW'(job_q.cx);
			py = RW'(job_q.cy);
		end else if (ay_q) begin
			px = fix;
			py = mv_q;
		end else begin
			px = mv_q;
			py = fix;
		end
		in_bounds = (px >= 0) && (px < RW'({1'b0, map_width})) &&
			(py >= 0) && (py < RW'({1'b0, map_height}));
		pix              = '0;
		pix.pixel_valid  = !job_q.idle || (st_q != B_AXIS);
		pix.in_map       = pix.pixel_valid && in_bounds;
		pix.tile_index   = pix.in_map ?
			IDXW'(py[MAPW-1:0] * map_width + IDXW'(px[MAPW-1:0])) : '0;
	end

	// closing result of a step
	always_comb begin
		last_pix              = pend_q;
		last_pix.last_of_step = 1'b1;
		last_pix.line_done    = job_q.done;
	end

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			B_IDLE: if (!q_empty) st_n = B_AXIS;
			B_AXIS: begin
				if (can_emit) begin
					st_n = (q_job_run(job_q)) ? B_SQ : B_END;
				end
			end
			B_SQ: st_n = B_TEST;
			B_TEST: begin
				if (!stop) st_n = B_EMIT;
				else if (next_rx) st_n = B_SQ;
				else st_n = B_END;
			end
			B_EMIT: if (can_emit) st_n = B_SQ;
			B_END: if (!out_v_q || res.ready) st_n = B_IDLE;
			default: st_n = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop    = 1'b0;
		do_emit  = 1'b0;
		do_flush = 1'b0;
		ld_run   = 1'b0;
		ld_ay    = 1'b0;
		adv      = 1'b0;
		set_cut  = 1'b0;
		case (st_q)
			B_IDLE: q_pop = !q_empty;
			B_AXIS: begin
				do_emit = can_emit;
				ld_run  = can_emit && q_job_run(job_q);
				ld_ay   = job_q.do_ry;
			end
			B_TEST: begin
				adv     = !stop;
				set_cut = run_ok;
				ld_run  = stop && next_rx;
				ld_ay   = 1'b0;
			end
			B_EMIT: do_emit = can_emit;
			B_END: do_flush = !out_v_q || res.ready;
			default: ;
		endcase
	end

	assign res.valid        = out_v_q;
	assign res.pixel_valid  = out_q.pixel_valid;
	assign res.in_map       = out_q.in_map;
	assign res.tile_index   = out_q.tile_index;
	assign res.run_cut      = out_q.run_cut;
	assign res.last_of_step = out_q.last_of_step;
	assign res.line_done    = out_q.line_done;

	// control state and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q <= st_n;
			if ((do_emit && pend_v_q) || do_flush) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			if (do_emit) begin
				pend_v_q <= 1'b1;
			end else if (do_flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// job, run walk and pixel payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (ld_run) begin
			ay_q <= ld_ay;
			mv_q <= ld_ay ? RW'(job_q.cy) : RW'(job_q.cx);
			e2_q <= ld_ay ? job_q.ry_e2 : job_q.rx_e2;
			k_q  <= '0;
		end else if (adv) begin
			mv_q <= mv_q + dir;
			e2_q <= e2_q + inc;
			k_q  <= k_q + 1'b1;
		end
		if (st_q == B_SQ) begin
			sq_q <= e2_q[EW-2:0] * e2_q[EW-2:0];
		end
		if (do_emit) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end
			pend_q <= pix;
		end else if (do_flush) begin
			out_q <= last_pix;
		end else if (set_cut && stop) begin
			pend_q.run_cut <= 1'b1;
		end
	end

endmodule

/* rtl/thick_line_rasterizer_top.sv */
// thick line rasterizer top level: configuration registers, front, job queue, back
// depends on tlr_pkg, tlr_if, tlr_front, tlr_fifo, tlr_back
//
// channel   role   carries
// cfg       sink   register index and data
// item      sink   kind, start_x, start_y, end_x, end_y
// res       source pixel_valid, in_map, tile_index, run_cut, last_of_step, line_done
//
// a start item takes the front through F_SQ and F_SUM (squares of the deltas, then their sum)
// a step item is queued as it is accepted; the back pops the job (B_IDLE), emits the
// axis pixel (B_AXIS), takes B_SQ, B_TEST, B_EMIT per run pixel through its squaring
// multiplier, B_SQ, B_TEST per run stop and B_END to close the step
// reset clears all control state; the queue lets front and back stall independently
`timescale 1ns / 1ps

module thick_line_rasterizer_top import tlr_pkg::*; #(
	parameter int RUN_LIMIT = RUN_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tlr_cfg_if.sink   cfg,
	tlr_item_if.sink  item,
	tlr_res_if.source res
);

	logic [MAPW-1:0] map_width_q, map_height_q;
	logic [LWW-1:0]  line_width_q;
	logic            q_push, q_pop, q_full, q_empty;
	job_t            q_din, q_dout;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAPW'(1024);
			map_height_q <= MAPW'(1024);
			line_width_q <= LWW'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg.data;
				CFG_MAP_HEIGHT: map_height_q <= cfg.data;
				CFG_LINE_WIDTH: line_width_q <= cfg.data[LWW-1:0];
				default: ;
			endcase
		end
	end

	tlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.line_width (line_width_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_din)
	);

	tlr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	tlr_back #(
		.RUN_LIMIT (RUN_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.q_empty    (q_empty),
		.q_job      (q_dout),
		.q_pop      (q_pop),
		.res        (res)
	);

	// no push into a full queue unless a pop frees an entry in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full && !q_pop))
		else $error("job queue overflow");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("job queue underflow");

	// pixels outside the map carry a zero index
	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.in_map |-> res.tile_index == '0)
		else $error("nonzero tile index outside map");

	// a done mark only comes with the end of a step
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.line_done |-> res.last_of_step)
		else $error("line_done without last_of_step");

endmodule
